FILE: rtl/rls_adaptive_pid_gain_update_unit_defines.svh
// Assertion macros used by the port-level checker of the adaptive gain unit.
`ifndef RLS_ADAPTIVE_PID_GAIN_UPDATE_UNIT_DEFINES_SVH
`define RLS_ADAPTIVE_PID_GAIN_UPDATE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held.
`define RLSPID_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is held.
`define RLSPID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rlspid_pkg.sv
// Package: constants, register indexes and fixed-point helpers of the gain unit.
package rlspid_pkg;

    localparam int FILTER_DELAY_DEF = 4;
    localparam int DIM              = 3;
    localparam int ADAPT_AFTER      = 3;
    localparam int STEP_MAX         = 4;
    localparam int DIV_STEPS        = 64;

    // Configuration register indexes
    localparam logic [1:0] CFG_INIT_COV   = 2'd0;
    localparam logic [1:0] CFG_FORGET     = 2'd1;
    localparam logic [1:0] CFG_FILT_GAIN  = 2'd2;

    // Register reset values (Q16.16 one)
    localparam logic [30:0]        INIT_COV_RST  = 31'd65536;
    localparam logic [16:0]        FORGET_RST    = 17'd65536;
    localparam logic signed [31:0] FILT_GAIN_RST = 32'sd65536;

    localparam logic signed [63:0] SAT_HI   = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO   = -64'sd2147483648;
    localparam logic signed [63:0] Q_HALF   = 64'sd32768;

    // Saturate a wide signed value to the Q16.16 range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > SAT_HI) begin
            r = 32'sh7fffffff;
        end else if (x < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Round a Q32.32 product to Q16.16: nearest, ties toward plus infinity
    function automatic logic signed [47:0] qround(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + Q_HALF) >>> 16;
        return s[47:0];
    endfunction

endpackage

FILE: rtl/rls_adaptive_pid_gain_update_unit.sv
// Adaptive PID gain unit: delay lines, RLS covariance and gain update, control output.
// Before adaptation starts an item only computes the control output, and the first item
// also loads the covariance. The input reopens as the result is registered, once the
// output register is free or being taken. Adapting items update the 9 covariance entries
// in turn, each by two 64-step bit-serial divisions (downdate by gamma, then by lambda).
// One item in flight at a time; the next item is accepted while a result waits.
// Synchronous reset (i_rst_n low) clears delay lines, gains, step count; resets registers.
module rls_adaptive_pid_gain_update_unit #(
    parameter int FILTER_DELAY = rlspid_pkg::FILTER_DELAY_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input items
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [31:0] error_now, [63:32] error_integral, [95:64] error_derivative,
    // [127:96] previous_control
    input  logic [127:0] i_s_tdata,
    // result items
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] control_out
    output logic [31:0]  o_m_tdata,
    // [0] adapting
    output logic [0:0]   o_m_tuser,
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_PF_M, S_PF_A, S_VW_R, S_VW_M1, S_VW_A1, S_VW_A2, S_VW_S,
        S_D_M, S_D_A, S_G_S, S_U_R, S_U_M, S_U_DS, S_DIV, S_U_P, S_U_W,
        S_DT_M, S_DT_A, S_E_S, S_K_R, S_K_M, S_K_A, S_G_M, S_G_A,
        S_O_M, S_O_A, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [30:0]        r_init_cov;
    logic [16:0]        r_forget;
    logic signed [31:0] r_filt_gain;
    logic [16:0]        lam_eff;

    // delay lines, newest at index 0
    logic signed [31:0] r_eh [0:FILTER_DELAY];
    logic signed [31:0] r_ih [0:FILTER_DELAY];
    logic signed [31:0] r_dh [0:FILTER_DELAY];
    logic signed [31:0] r_ch [0:FILTER_DELAY-1];

    // per-item working registers
    logic signed [31:0] r_phi [0:2];
    logic signed [31:0] r_pf  [0:2];
    logic signed [31:0] r_v   [0:2];
    logic signed [31:0] r_w   [0:2];
    logic signed [49:0] r_va  [0:2];
    logic signed [49:0] r_wa  [0:2];
    logic signed [31:0] r_gain [0:2];
    logic signed [31:0] r_uf;
    logic signed [31:0] r_e;
    logic signed [31:0] r_k;
    logic [30:0]        r_gam;
    logic signed [49:0] r_acc;
    logic [2:0]         r_step;
    logic               r_adapt;
    logic [1:0]         r_i;
    logic [1:0]         r_j;

    // shared multiplier
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] r_prod;
    logic signed [47:0] qv;

    // covariance memory, row major
    logic signed [31:0] r_cov_mem [0:8];
    logic signed [31:0] r_rd;
    logic [3:0]         addr;

    // bit-serial divider
    logic [63:0]        r_dq;
    logic [31:0]        r_dr;
    logic [31:0]        r_dd;
    logic               r_dneg;
    logic               r_dsel;
    logic [5:0]         r_dcnt;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic signed [63:0] dquot;
    logic signed [63:0] div_num;
    logic [31:0]        div_den;
    logic signed [31:0] p_sat;

    // output register
    logic               r_ovalid;
    logic [31:0]        r_odata;
    logic               r_ouser;

    logic               in_acc;
    logic               last_ij;
    logic signed [31:0] pf_tap;
    logic signed [63:0] gam_sum;
    logic signed [31:0] gam_sat;
    logic signed [63:0] e_sum;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;
    assign o_m_tuser   = r_ouser;
    assign in_acc      = i_s_tvalid && o_s_tready;

    assign lam_eff = (r_forget == '0) ? 17'd1 : r_forget;
    assign addr    = 4'(r_i) * 4'(rlspid_pkg::DIM) + 4'(r_j);
    assign last_ij = (r_i == 2'd2) && (r_j == 2'd2);
    assign qv      = rlspid_pkg::qround(r_prod);

    // filtered regressor taps
    always_comb begin
        case (r_i)
            2'd0:    pf_tap = r_eh[FILTER_DELAY];
            2'd1:    pf_tap = r_ih[FILTER_DELAY];
            2'd2:    pf_tap = r_dh[FILTER_DELAY];
            default: pf_tap = r_ch[FILTER_DELAY-1];
        endcase
    end

    // multiplier operand selection
    always_comb begin
        case (r_state)
            S_PF_M:  begin mul_a = r_filt_gain; mul_b = pf_tap;        end
            S_VW_M1: begin mul_a = r_rd;        mul_b = r_pf[r_j];     end
            S_VW_A1: begin mul_a = r_pf[r_i];   mul_b = r_rd;          end
            S_D_M:   begin mul_a = r_pf[r_i];   mul_b = r_v[r_i];      end
            S_U_M:   begin mul_a = r_v[r_i];    mul_b = r_w[r_j];      end
            S_DT_M:  begin mul_a = r_pf[r_i];   mul_b = r_gain[r_i];   end
            S_K_M:   begin mul_a = r_rd;        mul_b = r_pf[r_j];     end
            S_G_M:   begin mul_a = r_k;         mul_b = r_e;           end
            S_O_M:   begin mul_a = r_phi[r_i];  mul_b = r_gain[r_i];   end
            default: begin mul_a = '0;          mul_b = '0;            end
        endcase
    end

    // divider step and operand selection
    assign rem_sh = {r_dr, r_dq[63]};
    assign rem_ge = (rem_sh >= {1'b0, r_dd});
    assign dquot  = r_dneg ? -$signed(r_dq) : $signed(r_dq);
    assign p_sat  = rlspid_pkg::sat32(64'(r_rd) - dquot);

    always_comb begin
        if (r_state == S_U_DS) begin
            div_num = r_prod;
            div_den = {1'b0, r_gam};
        end else begin
            div_num = 64'(p_sat) <<< 16;
            div_den = {15'd0, lam_eff};
        end
    end

    // gamma and prediction error
    assign gam_sum = 64'($signed({1'b0, lam_eff})) + 64'(rlspid_pkg::sat32(64'(r_acc)));
    assign gam_sat = rlspid_pkg::sat32(gam_sum);
    assign e_sum   = 64'(r_phi[0]) + 64'(rlspid_pkg::sat32(64'(r_acc))) - 64'(r_uf);

    // multiplier pipeline register
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    // covariance memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_cov_mem[addr] <= (r_i == r_j) ? $signed({1'b0, r_init_cov}) : 32'sd0;
        end else if (r_state == S_U_W) begin
            r_cov_mem[addr] <= rlspid_pkg::sat32(dquot);
        end
        r_rd <= r_cov_mem[addr];
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init_cov  <= rlspid_pkg::INIT_COV_RST;
            r_forget    <= rlspid_pkg::FORGET_RST;
            r_filt_gain <= rlspid_pkg::FILT_GAIN_RST;
            r_step      <= '0;
            r_ovalid    <= 1'b0;
            r_adapt     <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_dcnt      <= '0;
            r_dsel      <= 1'b0;
            for (int k = 0; k <= FILTER_DELAY; k++) begin
                r_eh[k] <= '0;
                r_ih[k] <= '0;
                r_dh[k] <= '0;
            end
            for (int k = 0; k < FILTER_DELAY; k++) begin
                r_ch[k] <= '0;
            end
            for (int k = 0; k < 3; k++) begin
                r_gain[k] <= '0;
            end
        end else begin
            // configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rlspid_pkg::CFG_INIT_COV:  r_init_cov  <= i_cfg_data[30:0];
                    rlspid_pkg::CFG_FORGET:    r_forget    <= i_cfg_data[16:0];
                    rlspid_pkg::CFG_FILT_GAIN: r_filt_gain <= $signed(i_cfg_data);
                    default: ;
                endcase
            end

            // result taken downstream; S_DONE handles its own refill
            if (r_ovalid && i_m_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        for (int k = FILTER_DELAY; k > 0; k--) begin
                            r_eh[k] <= r_eh[k-1];
                            r_ih[k] <= r_ih[k-1];
                            r_dh[k] <= r_dh[k-1];
                        end
                        for (int k = FILTER_DELAY - 1; k > 0; k--) begin
                            r_ch[k] <= r_ch[k-1];
                        end
                        r_eh[0]  <= $signed(i_s_tdata[31:0]);
                        r_ih[0]  <= $signed(i_s_tdata[63:32]);
                        r_dh[0]  <= $signed(i_s_tdata[95:64]);
                        r_ch[0]  <= $signed(i_s_tdata[127:96]);
                        r_phi[0] <= $signed(i_s_tdata[31:0]);
                        r_phi[1] <= $signed(i_s_tdata[63:32]);
                        r_phi[2] <= $signed(i_s_tdata[95:64]);
                        r_adapt  <= (r_step > 3'(rlspid_pkg::ADAPT_AFTER));
                        if (r_step < 3'(rlspid_pkg::STEP_MAX)) begin
                            r_step <= r_step + 3'd1;
                        end
                        r_i   <= '0;
                        r_j   <= '0;
                        r_acc <= '0;
                        if (r_step == '0) begin
                            r_state <= S_LOAD;
                        end else if (r_step > 3'(rlspid_pkg::ADAPT_AFTER)) begin
                            r_state <= S_PF_M;
                        end else begin
                            r_state <= S_O_M;
                        end
                    end
                end

                // covariance = p0 * identity
                S_LOAD: begin
                    if (last_ij) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= S_O_M;
                    end else if (r_j == 2'd2) begin
                        r_j <= '0;
                        r_i <= r_i + 2'd1;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end

                // filtered regressor and filtered control
                S_PF_M: r_state <= S_PF_A;
                S_PF_A: begin
                    if (r_i == 2'd3) begin
                        r_uf <= rlspid_pkg::sat32(64'(qv));
                        r_i  <= '0;
                        r_j  <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_va[k] <= '0;
                            r_wa[k] <= '0;
                        end
                        r_state <= S_VW_R;
                    end else begin
                        r_pf[r_i] <= rlspid_pkg::sat32(64'(qv));
                        r_i       <= r_i + 2'd1;
                        r_state   <= S_PF_M;
                    end
                end

                // v = P pf, w = pf' P
                S_VW_R:  r_state <= S_VW_M1;
                S_VW_M1: r_state <= S_VW_A1;
                S_VW_A1: begin
                    r_va[r_i] <= r_va[r_i] + 50'(qv);
                    r_state   <= S_VW_A2;
                end
                S_VW_A2: begin
                    r_wa[r_j] <= r_wa[r_j] + 50'(qv);
                    if (last_ij) begin
                        r_state <= S_VW_S;
                    end else begin
                        if (r_j == 2'd2) begin
                            r_j <= '0;
                            r_i <= r_i + 2'd1;
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                        r_state <= S_VW_R;
                    end
                end
                S_VW_S: begin
                    for (int k = 0; k < 3; k++) begin
                        r_v[k] <= rlspid_pkg::sat32(64'(r_va[k]));
                        r_w[k] <= rlspid_pkg::sat32(64'(r_wa[k]));
                    end
                    r_i     <= '0;
                    r_j     <= '0;
                    r_acc   <= '0;
                    r_state <= S_D_M;
                end

                // d = pf . v
                S_D_M: r_state <= S_D_A;
                S_D_A: begin
                    r_acc <= r_acc + 50'(qv);
                    if (r_i == 2'd2) begin
                        r_state <= S_G_S;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_D_M;
                    end
                end
                S_G_S: begin
                    r_gam   <= (gam_sat < 32'sd1) ? 31'd1 : gam_sat[30:0];
                    r_i     <= '0;
                    r_j     <= '0;
                    r_state <= S_U_R;
                end

                // covariance downdate and forgetting, one entry at a time
                S_U_R: r_state <= S_U_M;
                S_U_M: r_state <= S_U_DS;
                S_U_DS, S_U_P: begin
                    r_dneg  <= div_num[63];
                    r_dq    <= div_num[63] ? 64'(-div_num) : 64'(div_num);
                    r_dr    <= '0;
                    r_dd    <= div_den;
                    r_dcnt  <= 6'(rlspid_pkg::DIV_STEPS - 1);
                    r_dsel  <= (r_state == S_U_P);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dr   <= rem_ge ? 32'(rem_sh - {1'b0, r_dd}) : rem_sh[31:0];
                    r_dq   <= {r_dq[62:0], rem_ge};
                    r_dcnt <= r_dcnt - 6'd1;
                    if (r_dcnt == '0) begin
                        r_state <= r_dsel ? S_U_W : S_U_P;
                    end
                end
                S_U_W: begin
                    if (last_ij) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_acc   <= '0;
                        r_state <= S_DT_M;
                    end else begin
                        if (r_j == 2'd2) begin
                            r_j <= '0;
                            r_i <= r_i + 2'd1;
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                        r_state <= S_U_R;
                    end
                end

                // prediction error e = z + pf . gains - uf
                S_DT_M: r_state <= S_DT_A;
                S_DT_A: begin
                    r_acc <= r_acc + 50'(qv);
                    if (r_i == 2'd2) begin
                        r_state <= S_E_S;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_DT_M;
                    end
                end
                S_E_S: begin
                    r_e     <= rlspid_pkg::sat32(e_sum);
                    r_i     <= '0;
                    r_j     <= '0;
                    r_acc   <= '0;
                    r_state <= S_K_R;
                end

                // k = P pf, then gain row update
                S_K_R: r_state <= S_K_M;
                S_K_M: r_state <= S_K_A;
                S_K_A: begin
                    if (r_j == 2'd2) begin
                        r_k     <= rlspid_pkg::sat32(64'(r_acc + 50'(qv)));
                        r_state <= S_G_M;
                    end else begin
                        r_acc   <= r_acc + 50'(qv);
                        r_j     <= r_j + 2'd1;
                        r_state <= S_K_R;
                    end
                end
                S_G_M: r_state <= S_G_A;
                S_G_A: begin
                    r_gain[r_i] <= rlspid_pkg::sat32(64'(r_gain[r_i]) - 64'(qv));
                    r_acc       <= '0;
                    r_j         <= '0;
                    if (r_i == 2'd2) begin
                        r_i     <= '0;
                        r_state <= S_O_M;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_K_R;
                    end
                end

                // control = phi . gains
                S_O_M: r_state <= S_O_A;
                S_O_A: begin
                    r_acc <= r_acc + 50'(qv);
                    if (r_i == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_O_M;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= rlspid_pkg::sat32(64'(r_acc));
                        r_ouser  <= r_adapt;
                        r_state  <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/rlspid_chk.sv
// Port-level checker for the adaptive gain unit, bound to the top level.
`include "rls_adaptive_pid_gain_update_unit_defines.svh"

module rlspid_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [127:0] i_s_tdata,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [31:0]  o_m_tdata,
    input logic [0:0]   o_m_tuser,
    input logic         i_cfg_valid,
    input logic         o_cfg_ready,
    input logic [1:0]   i_cfg_index,
    input logic [31:0]  i_cfg_data
);

    // a stalled result keeps its payload
    `RLSPID_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed while stalled")

    // an accepted item occupies the block
    `RLSPID_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready, "ready stayed high after an item was taken")

    // a new result only appears as the block returns to idle
    `RLSPID_ASSERT_NOW(a_result_at_idle, $rose(o_m_tvalid), o_s_tready, "result appeared while busy")

    // configuration writes are never stalled
    `RLSPID_ASSERT_NOW(a_cfg_ready, i_cfg_valid, o_cfg_ready, "configuration write stalled")

endmodule

bind rls_adaptive_pid_gain_update_unit rlspid_chk u_rlspid_chk (.*);

FILE: verif/rls_adaptive_pid_gain_update_unit_chk.sv
// Checker for the adaptive gain unit: watches all channels, predicts and compares results.
`timescale 1ns / 1ps

module rls_adaptive_pid_gain_update_unit_chk (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [127:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [31:0]  i_m_tdata,
    input  logic [0:0]   i_m_tuser,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_results,
    output int           o_adapting
);

    localparam int DLY = rlspid_pkg::FILTER_DELAY_DEF;

    typedef struct packed {
        logic signed [31:0] control;
        logic               adapting;
    } t_control;

    t_control expected_controls[$];

    // model copy of registers and state
    longint p0_reg, lambda_reg, fgain_reg;
    longint err_hist[DLY+1], int_hist[DLY+1], der_hist[DLY+1], ctl_hist[DLY];
    longint cov[9], gain[3];
    int     steps;

    assign o_pending = expected_controls.size();

    function automatic longint sat_q(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 product, rounded to nearest, ties up
    function automatic longint mul_q(input longint a, input longint b);
        longint p;
        p = a * b + 32768;
        if (p >= 0) return p / 65536;
        return -((-p + 65535) / 65536);
    endfunction

    function automatic longint sx(input logic [31:0] x);
        return longint'(signed'(x));
    endfunction

    task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
        $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
        o_fail_count++;
    endtask

    // one RLS step of the gain unit; queues the expected control
    task automatic compute_control(input logic [127:0] d);
        longint   phi[3], pf[3], v[3], w[3], k[3];
        longint   lam, uf, dd, gam, dot, e, t, p, s, sv, sw, uk;
        logic     adapt;
        t_control c;
        phi[0] = sx(d[31:0]);
        phi[1] = sx(d[63:32]);
        phi[2] = sx(d[95:64]);
        if (steps == 0) begin
            foreach (cov[i]) cov[i] = 0;
            cov[0] = p0_reg;
            cov[4] = p0_reg;
            cov[8] = p0_reg;
        end
        for (int i = DLY-1; i > 0; i--) ctl_hist[i] = ctl_hist[i-1];
        ctl_hist[0] = sx(d[127:96]);
        for (int i = DLY; i > 0; i--) begin
            err_hist[i] = err_hist[i-1];
            int_hist[i] = int_hist[i-1];
            der_hist[i] = der_hist[i-1];
        end
        err_hist[0] = phi[0];
        int_hist[0] = phi[1];
        der_hist[0] = phi[2];

        adapt = steps > rlspid_pkg::ADAPT_AFTER;
        if (adapt) begin
            // lambda of zero behaves as one LSB
            lam   = (lambda_reg != 0) ? lambda_reg : 1;
            pf[0] = sat_q(mul_q(fgain_reg, err_hist[DLY]));
            pf[1] = sat_q(mul_q(fgain_reg, int_hist[DLY]));
            pf[2] = sat_q(mul_q(fgain_reg, der_hist[DLY]));
            uf    = sat_q(mul_q(fgain_reg, ctl_hist[DLY-1]));
            for (int i = 0; i < 3; i++) begin
                sv = 0;
                sw = 0;
                for (int j = 0; j < 3; j++) begin
                    sv += mul_q(cov[i*3+j], pf[j]);
                    sw += mul_q(pf[j], cov[j*3+i]);
                end
                v[i] = sat_q(sv);
                w[i] = sat_q(sw);
            end
            dd  = sat_q(mul_q(pf[0], v[0]) + mul_q(pf[1], v[1]) + mul_q(pf[2], v[2]));
            gam = sat_q(lam + dd);
            if (gam < 1) gam = 1;   // non-positive gamma clamps to one LSB
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    t = (v[i] * w[j]) / gam;
                    p = sat_q(cov[i*3+j] - t);
                    cov[i*3+j] = sat_q((p * 65536) / lam);
                end
            end
            dot = sat_q(mul_q(pf[0], gain[0]) + mul_q(pf[1], gain[1]) + mul_q(pf[2], gain[2]));
            e   = sat_q(phi[0] + dot - uf);
            for (int i = 0; i < 3; i++) begin
                s = 0;
                for (int j = 0; j < 3; j++) s += mul_q(cov[i*3+j], pf[j]);
                k[i] = sat_q(s);
            end
            for (int i = 0; i < 3; i++) gain[i] = sat_q(gain[i] - mul_q(k[i], e));
        end
        uk = 0;
        for (int j = 0; j < 3; j++) uk += mul_q(phi[j], gain[j]);
        uk = sat_q(uk);
        if (steps < rlspid_pkg::STEP_MAX) steps++;
        c.control  = uk[31:0];
        c.adapting = adapt;
        expected_controls.push_back(c);
    endtask

    always @(posedge i_clk) begin
        t_control c;
        if (!i_rst_n) begin
            p0_reg     = 65536;
            lambda_reg = 65536;
            fgain_reg  = 65536;
            foreach (err_hist[i]) begin
                err_hist[i] = 0;
                int_hist[i] = 0;
                der_hist[i] = 0;
            end
            foreach (ctl_hist[i]) ctl_hist[i] = 0;
            foreach (cov[i]) cov[i] = 0;
            foreach (gain[i]) gain[i] = 0;
            steps = 0;
            expected_controls.delete();
            o_fail_count = 0;
            o_results    = 0;
            o_adapting   = 0;
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    rlspid_pkg::CFG_INIT_COV:  p0_reg = longint'(i_cfg_data[30:0]);
                    rlspid_pkg::CFG_FORGET:    lambda_reg = longint'(i_cfg_data[16:0]);
                    rlspid_pkg::CFG_FILT_GAIN: fgain_reg = sx(i_cfg_data);
                    default: ;
                endcase
            end
            // results first: the block holds one item in flight
            if (i_m_tvalid && i_m_tready) begin
                if (expected_controls.size() == 0) begin
                    report_mismatch("unexpected result, control", 0, sx(i_m_tdata));
                end else begin
                    c = expected_controls.pop_front();
                    if (i_m_tdata !== c.control)
                        report_mismatch("control_out", sx(c.control), sx(i_m_tdata));
                    if (i_m_tuser[0] !== c.adapting)
                        report_mismatch("adapting", c.adapting, i_m_tuser[0]);
                    o_results++;
                    if (c.adapting) o_adapting++;
                end
            end
            if (i_s_tvalid && i_s_tready) compute_control(i_s_tdata);
        end
    end

endmodule

FILE: verif/rls_adaptive_pid_gain_update_unit_tb.sv
// Testbench top for the adaptive gain unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rls_adaptive_pid_gain_update_unit_tb;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    int fail_count, pending, n_results, n_adapting;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    rls_adaptive_pid_gain_update_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .o_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    rls_adaptive_pid_gain_update_unit_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results(n_results), .o_adapting(n_adapting)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // result side: random stalls, plus one long hold-off to back up the input
    initial begin
        int cyc;
        int hold;
        cyc  = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == 3000) hold = 4000;
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Q16.16 operand: mostly moderate, some full range and extremes
    function automatic logic [31:0] pick_q();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 32'($signed($urandom_range(524288)) - 262144);
        if (r < 85) return $urandom;
        if (r < 90) return 32'h7fffffff;
        if (r < 95) return 32'h80000000;
        return 32'h0;
    endfunction

    task automatic send_sample(input logic [31:0] z, input logic [31:0] zi,
                               input logic [31:0] zd, input logic [31:0] u);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {u, zd, zi, z};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // drain: every expected result back, then an idle gap
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] p0_set[5], lam_set[5], fg_set[5];
        p0_set  = '{32'h7fffffff, 32'd1, 32'd6553600, 32'd0, 32'd65536};
        lam_set = '{32'd131071, 32'd0, 32'd64880, 32'd1, 32'd65536};
        fg_set  = '{32'h7fffffff, 32'hffff0000, 32'h80000000, 32'd32768, 32'd65536};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // covariance seed before the first item
        write_reg(rlspid_pkg::CFG_INIT_COV, 32'd196608);

        // directed: field extremes, first-item load, start of adaptation
        send_sample(32'h0, 32'h0, 32'h0, 32'h0);
        send_sample(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_sample(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_sample(32'h00010000, 32'hffff0000, 32'h00008000, 32'hffff8000);
        send_sample(32'h00020000, 32'h00010000, 32'hffff0000, 32'h00010000);
        send_sample(32'h7fffffff, 32'h80000000, 32'h0, 32'h00010000);
        send_sample(32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h0);
        send_sample(32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000);
        for (int i = 0; i < 12; i++)
            send_sample(32'h8000 * (i - 6), 32'h4000 * i, 32'hffff0000 + i, 32'h10000 * i);
        drain();

        // random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin send_idle_pct = 29; recv_idle_pct = 87; end
                1: begin send_idle_pct = 87; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (ph > 0) begin
                write_reg(rlspid_pkg::CFG_INIT_COV, p0_set[ph-1]);
                write_reg(rlspid_pkg::CFG_FORGET, lam_set[ph-1]);
                write_reg(rlspid_pkg::CFG_FILT_GAIN, fg_set[ph-1]);
            end
            for (int n = 0; n < 72; n++)
                send_sample(pick_q(), pick_q(), pick_q(), pick_q());
            drain();
        end

        $display("Run covered %0d results, %0d with gain adaptation,", n_results, n_adapting);
        $display("across six register settings including lambda zero and above one.");
        if (fail_count == 0 && pending == 0) begin
            $display("rls_adaptive_pid_gain_update_unit verification clean");
        end else begin
            $display("rls_adaptive_pid_gain_update_unit verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("Timeout with %0d results outstanding", pending);
        $display("rls_adaptive_pid_gain_update_unit verification failed");
        $finish;
    end

endmodule
